// ===== hw/rtl/ste_pkg.sv =====
// ----------------------------------------------------------------------------
// ste_pkg
// Shared widths, command and status types and the exponent table of the
// shaped trapezoid envelope.
// ----------------------------------------------------------------------------
package ste_pkg;

  localparam int LEN_W  = 20;
  localparam int SMP_W  = 16;
  localparam int SHP_W  = 16;
  localparam int GAIN_W = 16;
  localparam int IDX_W  = 2;
  localparam int CFGD_W = 20;
  localparam int IN_W   = 56;
  localparam int OUT_W  = 40;
  localparam int NUM_W  = 40;
  localparam int DEN_W  = 21;

  localparam logic [IDX_W-1:0] REG_ATTACK_LEN   = 2'd0;
  localparam logic [IDX_W-1:0] REG_DECAY_LEN    = 2'd1;
  localparam logic [IDX_W-1:0] REG_ATTACK_SHAPE = 2'd2;
  localparam logic [IDX_W-1:0] REG_DECAY_SHAPE  = 2'd3;

  localparam logic [1:0] PH_ATTACK = 2'd0;
  localparam logic [1:0] PH_HOLD   = 2'd1;
  localparam logic [1:0] PH_DECAY  = 2'd2;

  localparam logic [SHP_W-1:0] SHAPE_ONE = 16'd4096;

  // datapath operations
  localparam logic [4:0] OP_NOP        = 5'd0;
  localparam logic [4:0] OP_LATCH      = 5'd1;
  localparam logic [4:0] OP_ST_INIT    = 5'd2;
  localparam logic [4:0] OP_MUL_A      = 5'd3;
  localparam logic [4:0] OP_DIV_PROD   = 5'd4;
  localparam logic [4:0] OP_TAKE_A     = 5'd5;
  localparam logic [4:0] OP_TAKE_D     = 5'd6;
  localparam logic [4:0] OP_SWAP       = 5'd7;
  localparam logic [4:0] OP_LOAD       = 5'd8;
  localparam logic [4:0] OP_STEP_POS   = 5'd9;
  localparam logic [4:0] OP_SH_INIT    = 5'd10;
  localparam logic [4:0] OP_NORM       = 5'd11;
  localparam logic [4:0] OP_MUL_SQ     = 5'd12;
  localparam logic [4:0] OP_SQ_USE     = 5'd13;
  localparam logic [4:0] OP_MUL_EXP    = 5'd14;
  localparam logic [4:0] OP_EXP_USE    = 5'd15;
  localparam logic [4:0] OP_MUL_TAB    = 5'd16;
  localparam logic [4:0] OP_TAB_USE    = 5'd17;
  localparam logic [4:0] OP_TAB_SKIP   = 5'd18;
  localparam logic [4:0] OP_SHIFT      = 5'd19;
  localparam logic [4:0] OP_MUL_MAG    = 5'd20;
  localparam logic [4:0] OP_TAKE_M1    = 5'd21;
  localparam logic [4:0] OP_MUL_GAIN   = 5'd22;
  localparam logic [4:0] OP_SAT        = 5'd23;
  localparam logic [4:0] OP_UPD        = 5'd24;
  localparam logic [4:0] OP_STEP_NEG   = 5'd25;
  localparam logic [4:0] OP_EMIT       = 5'd26;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic act;
    logic shortcut;
    logic scale;
    logic m_norm;
    logic cnt_last;
    logic cnt_zero;
    logic q_big;
    logic f_bit;
    logic a_zero;
    logic dec_div;
    logic div_done;
    logic out_free;
  } sts_t;

  typedef logic [15:0][31:0] tab_t;

  function automatic logic [31:0] isqrt64(input logic [63:0] v);
    logic [31:0] r;
    logic [31:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (({32'd0, t} * {32'd0, t}) <= v) r = t;
    end
    return r;
  endfunction

  // c[j] = 2^31 * 2^(-2^(j-16)), built by repeated square roots
  function automatic tab_t build_tab();
    tab_t t;
    t[15] = isqrt64(64'd1 << 61);
    for (int j = 15; j > 0; j--) begin
      t[j-1] = isqrt64({1'b0, t[j], 31'd0});
    end
    return t;
  endfunction

  localparam tab_t EXP_TAB = build_tab();

endpackage

// ===== hw/rtl/ste_div.sv =====
// ----------------------------------------------------------------------------
// ste_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ste_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ste_pkg::NUM_W-1:0] num,
  input  logic [ste_pkg::DEN_W-1:0] den,
  output logic [ste_pkg::NUM_W-1:0] quot,
  output logic                      done
);
  import ste_pkg::*;

  logic [NUM_W-1:0] nreg;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dreg;
  logic [5:0]       cnt;
  logic [DEN_W:0]   trial;
  logic             qbit;

  assign trial = {rem, nreg[NUM_W-1]};
  assign qbit  = (trial >= {1'b0, dreg});
  assign quot  = nreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        nreg <= num;
        dreg <= den;
        rem  <= '0;
        cnt  <= 6'(NUM_W);
      end else if (cnt != '0) begin
        // shift in one numerator bit, subtract where it fits
        rem  <= qbit ? DEN_W'(trial - {1'b0, dreg}) : trial[DEN_W-1:0];
        nreg <= {nreg[NUM_W-2:0], qbit};
        cnt  <= cnt - 6'd1;
        done <= (cnt == 6'd1);
      end
    end
  end

endmodule

// ===== hw/rtl/ste_datapath.sv =====
// ----------------------------------------------------------------------------
// ste_datapath
// Registers, shared multiplier and divider of the envelope; runs one
// operation per cycle as the controller commands.
// ----------------------------------------------------------------------------
module ste_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  ste_pkg::cmd_t              cmd,
  output ste_pkg::sts_t              sts,
  input  logic                       cfg_valid,
  input  logic [ste_pkg::IDX_W-1:0]  cfg_index,
  input  logic [ste_pkg::CFGD_W-1:0] cfg_data,
  input  logic [ste_pkg::IN_W-1:0]   in_data,
  input  logic                       in_user,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ste_pkg::OUT_W-1:0]  out_data
);
  import ste_pkg::*;

  // configuration
  logic [LEN_W-1:0] attack_len, decay_len;
  logic [SHP_W-1:0] attack_shape, decay_shape;

  // latched item
  logic              act, rev;
  logic [LEN_W-1:0]  len;
  logic [SMP_W-1:0]  smp;
  logic [GAIN_W-1:0] gain;

  // envelope state
  logic [31:0]       level;
  logic signed [32:0] step;
  logic [1:0]        phase;
  logic [LEN_W:0]    remaining;
  logic [SHP_W-1:0]  cur_shape;
  logic [LEN_W-1:0]  eff_decay, hold_len;

  // work registers
  logic [LEN_W-1:0]  ra, rd;
  logic [LEN_W:0]    sum;
  logic [31:0]       m, r;
  logic [4:0]        k, q;
  logic [15:0]       fr, f;
  logic [3:0]        cnt;
  logic [16:0]       m1;
  logic [SMP_W-1:0]  res_sample;
  logic [15:0]       res_level;
  logic [1:0]        res_phase;
  logic [63:0]       prod;

  logic [31:0]       mul_a, mul_b;
  logic [16:0]       mag;
  logic [20:0]       neg;
  logic [32:0]       sq;
  logic              negs;
  logic [18:0]       m2;
  logic [16:0]       m2c;
  logic signed [33:0] nl;
  logic              live;
  logic [LEN_W-1:0]  hold_calc;

  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic [NUM_W-1:0]  div_quot;
  logic              div_done;

  ste_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .done  (div_done)
  );

  assign negs      = smp[SMP_W-1];
  assign mag       = negs ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
  assign neg       = {k, 16'd0} - {5'd0, fr};
  assign sq        = prod[63:31];
  assign m2        = prod[32:14];
  assign live      = (remaining != '0);
  assign nl        = $signed({2'b00, level}) + $signed({step[32], step});
  assign hold_calc = len - ra - rd;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_A:    begin mul_a = 32'(ra);        mul_b = 32'(len); end
      OP_TAKE_A:   begin mul_a = 32'(rd);        mul_b = 32'(len); end
      OP_MUL_SQ:   begin mul_a = m;              mul_b = m; end
      OP_MUL_EXP:  begin mul_a = 32'(neg);       mul_b = 32'(cur_shape); end
      OP_MUL_TAB:  begin mul_a = r;              mul_b = EXP_TAB[cnt]; end
      OP_MUL_MAG:  begin mul_a = 32'(mag);       mul_b = r; end
      OP_MUL_GAIN: begin mul_a = 32'(m1);        mul_b = 32'(gain); end
      default:     begin mul_a = '0;             mul_b = '0; end
    endcase
  end

  // divider start and operands
  always_comb begin
    div_start = 1'b0;
    div_num   = NUM_W'(33'h080000000);
    div_den   = {1'b0, ra};
    case (cmd.op)
      OP_DIV_PROD: begin
        div_start = 1'b1;
        div_num   = prod[NUM_W-1:0];
        div_den   = sum;
      end
      OP_LOAD: div_start = (ra != '0);
      OP_UPD: begin
        div_start = sts.dec_div;
        div_den   = {1'b0, eff_decay};
      end
      default: div_start = 1'b0;
    endcase
  end

  always_comb begin
    m2c = (m2 > 19'd32768) ? 17'h08000 : m2[16:0];
  end

  always_comb begin
    sts.act      = act;
    sts.shortcut = (cur_shape == '0) || level[31] || (level == '0) ||
                   (cur_shape == SHAPE_ONE);
    sts.scale    = ({1'b0, len} < sum);
    sts.m_norm   = m[31];
    sts.cnt_last = (cnt == 4'd15);
    sts.cnt_zero = (cnt == 4'd0);
    sts.q_big    = |prod[63:33];
    sts.f_bit    = f[cnt];
    sts.a_zero   = (ra == '0);
    sts.dec_div  = !live && (phase == PH_HOLD) && (eff_decay != '0);
    sts.div_done = div_done;
    sts.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_len   <= LEN_W'(480);
      decay_len    <= LEN_W'(480);
      attack_shape <= SHAPE_ONE;
      decay_shape  <= SHAPE_ONE;
      level        <= '0;
      step         <= '0;
      phase        <= PH_ATTACK;
      remaining    <= '0;
      cur_shape    <= '0;
      eff_decay    <= '0;
      hold_len     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_ATTACK_LEN:   attack_len   <= cfg_data[LEN_W-1:0];
          REG_DECAY_LEN:    decay_len    <= cfg_data[LEN_W-1:0];
          REG_ATTACK_SHAPE: attack_shape <= cfg_data[SHP_W-1:0];
          REG_DECAY_SHAPE:  decay_shape  <= cfg_data[SHP_W-1:0];
          default:          attack_len   <= attack_len;
        endcase
      end
      if (cmd.op == OP_EMIT)           out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;

      case (cmd.op)
        OP_LATCH: begin
          act  <= in_user;
          len  <= in_data[19:0];
          rev  <= in_data[20];
          smp  <= in_data[36:21];
          gain <= in_data[52:37];
        end
        OP_ST_INIT: begin
          ra  <= attack_len;
          rd  <= decay_len;
          sum <= {1'b0, attack_len} + {1'b0, decay_len};
        end
        OP_TAKE_A: ra <= div_quot[LEN_W-1:0];
        OP_TAKE_D: rd <= div_quot[LEN_W-1:0];
        OP_SWAP: begin
          if (rev) begin
            ra <= rd;
            rd <= ra;
          end
        end
        OP_LOAD: begin
          eff_decay <= rd;
          hold_len  <= hold_calc;
          if (ra != '0) begin
            level     <= '0;
            phase     <= PH_ATTACK;
            remaining <= {1'b0, ra};
            cur_shape <= attack_shape;
          end else begin
            level     <= 32'h80000000;
            phase     <= PH_HOLD;
            step      <= '0;
            remaining <= {1'b0, hold_calc};
            cur_shape <= SHAPE_ONE;
          end
        end
        OP_STEP_POS: step <= {1'b0, div_quot[31:0]};
        OP_STEP_NEG: step <= -$signed({1'b0, div_quot[31:0]});
        OP_SH_INIT: begin
          m   <= level;
          k   <= '0;
          fr  <= '0;
          cnt <= '0;
          if ((cur_shape == '0) || level[31]) r <= 32'h80000000;
          else if (level == '0)               r <= '0;
          else                                r <= level;
        end
        OP_NORM: begin
          if (!m[31]) begin
            m <= {m[30:0], 1'b0};
            k <= k + 5'd1;
          end
        end
        OP_SQ_USE: begin
          fr  <= {fr[14:0], sq[32]};
          m   <= sq[32] ? sq[32:1] : sq[31:0];
          cnt <= cnt + 4'd1;
        end
        OP_EXP_USE: begin
          f   <= prod[27:12];
          q   <= prod[32:28];
          r   <= (|prod[63:33]) ? 32'd0 : 32'h80000000;
          cnt <= 4'd15;
        end
        OP_TAB_USE: begin
          r   <= prod[62:31];
          cnt <= cnt - 4'd1;
        end
        OP_TAB_SKIP: cnt <= cnt - 4'd1;
        OP_SHIFT:    r   <= r >> q;
        OP_TAKE_M1:  m1  <= prod[47:31];
        OP_SAT: begin
          if (negs) res_sample <= SMP_W'(17'h10000 - m2c);
          else      res_sample <= (m2 > 19'd32767) ? 16'h7FFF : m2[15:0];
          res_level <= level[31:16];
          res_phase <= phase;
        end
        OP_UPD: begin
          if (live) begin
            remaining <= remaining - (LEN_W+1)'(1);
            if (nl < 0)                       level <= '0;
            else if (nl > 34'sh080000000)     level <= 32'h80000000;
            else                              level <= nl[31:0];
          end else if (phase == PH_ATTACK) begin
            phase     <= PH_HOLD;
            level     <= 32'h80000000;
            step      <= '0;
            cur_shape <= SHAPE_ONE;
            remaining <= {1'b0, hold_len};
          end else if (phase == PH_HOLD) begin
            phase     <= PH_DECAY;
            remaining <= {1'b0, eff_decay};
            cur_shape <= decay_shape;
            if (eff_decay == '0) begin
              level <= '0;
              step  <= '0;
            end
          end else begin
            remaining <= remaining - (LEN_W+1)'(1);
          end
        end
        OP_EMIT: begin
          out_data  <= {6'd0, res_phase, res_level, res_sample};
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ste_ctrl.sv =====
// ----------------------------------------------------------------------------
// ste_ctrl
// Sequencer of the envelope: walks the datapath through grain start and
// sample processing.
// ----------------------------------------------------------------------------
module ste_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ste_pkg::sts_t sts,
  output ste_pkg::cmd_t cmd
);
  import ste_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISPATCH = 5'd1;
  localparam logic [4:0] S_SCALE    = 5'd2;
  localparam logic [4:0] S_DIVA     = 5'd3;
  localparam logic [4:0] S_WA       = 5'd4;
  localparam logic [4:0] S_DIVD     = 5'd5;
  localparam logic [4:0] S_WD       = 5'd6;
  localparam logic [4:0] S_SWAP     = 5'd7;
  localparam logic [4:0] S_LOAD     = 5'd8;
  localparam logic [4:0] S_WS       = 5'd9;
  localparam logic [4:0] S_NORM     = 5'd10;
  localparam logic [4:0] S_SQ_MUL   = 5'd11;
  localparam logic [4:0] S_SQ_USE   = 5'd12;
  localparam logic [4:0] S_EXP_MUL  = 5'd13;
  localparam logic [4:0] S_EXP_USE  = 5'd14;
  localparam logic [4:0] S_TAB      = 5'd15;
  localparam logic [4:0] S_TAB_USE  = 5'd16;
  localparam logic [4:0] S_SHIFT    = 5'd17;
  localparam logic [4:0] S_MUL_MAG  = 5'd18;
  localparam logic [4:0] S_TAKE_M1  = 5'd19;
  localparam logic [4:0] S_MUL_GAIN = 5'd20;
  localparam logic [4:0] S_SAT      = 5'd21;
  localparam logic [4:0] S_UPD      = 5'd22;
  localparam logic [4:0] S_WDD      = 5'd23;
  localparam logic [4:0] S_EMIT     = 5'd24;

  logic [4:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!sts.act) begin
          cmd.op     = OP_ST_INIT;
          state_next = S_SCALE;
        end else begin
          cmd.op     = OP_SH_INIT;
          state_next = sts.shortcut ? S_MUL_MAG : S_NORM;
        end
      end
      S_SCALE: begin
        if (sts.scale) begin
          cmd.op     = OP_MUL_A;
          state_next = S_DIVA;
        end else begin
          state_next = S_SWAP;
        end
      end
      S_DIVA: begin
        cmd.op     = OP_DIV_PROD;
        state_next = S_WA;
      end
      S_WA: begin
        if (sts.div_done) begin
          cmd.op     = OP_TAKE_A;
          state_next = S_DIVD;
        end
      end
      S_DIVD: begin
        cmd.op     = OP_DIV_PROD;
        state_next = S_WD;
      end
      S_WD: begin
        if (sts.div_done) begin
          cmd.op     = OP_TAKE_D;
          state_next = S_SWAP;
        end
      end
      S_SWAP: begin
        cmd.op     = OP_SWAP;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.op     = OP_LOAD;
        state_next = sts.a_zero ? S_IDLE : S_WS;
      end
      S_WS: begin
        if (sts.div_done) begin
          cmd.op     = OP_STEP_POS;
          state_next = S_IDLE;
        end
      end
      S_NORM: begin
        cmd.op = OP_NORM;
        if (sts.m_norm) state_next = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        cmd.op     = OP_MUL_SQ;
        state_next = S_SQ_USE;
      end
      S_SQ_USE: begin
        cmd.op     = OP_SQ_USE;
        state_next = sts.cnt_last ? S_EXP_MUL : S_SQ_MUL;
      end
      S_EXP_MUL: begin
        cmd.op     = OP_MUL_EXP;
        state_next = S_EXP_USE;
      end
      S_EXP_USE: begin
        cmd.op     = OP_EXP_USE;
        state_next = sts.q_big ? S_MUL_MAG : S_TAB;
      end
      S_TAB: begin
        if (sts.f_bit) begin
          cmd.op     = OP_MUL_TAB;
          state_next = S_TAB_USE;
        end else begin
          cmd.op = OP_TAB_SKIP;
          if (sts.cnt_zero) state_next = S_SHIFT;
        end
      end
      S_TAB_USE: begin
        cmd.op     = OP_TAB_USE;
        state_next = sts.cnt_zero ? S_SHIFT : S_TAB;
      end
      S_SHIFT: begin
        cmd.op     = OP_SHIFT;
        state_next = S_MUL_MAG;
      end
      S_MUL_MAG: begin
        cmd.op     = OP_MUL_MAG;
        state_next = S_TAKE_M1;
      end
      S_TAKE_M1: begin
        cmd.op     = OP_TAKE_M1;
        state_next = S_MUL_GAIN;
      end
      S_MUL_GAIN: begin
        cmd.op     = OP_MUL_GAIN;
        state_next = S_SAT;
      end
      S_SAT: begin
        cmd.op     = OP_SAT;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.op     = OP_UPD;
        state_next = sts.dec_div ? S_WDD : S_EMIT;
      end
      S_WDD: begin
        if (sts.div_done) begin
          cmd.op     = OP_STEP_NEG;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

// ===== hw/rtl/shaped_trapezoid_envelope.sv =====
// ----------------------------------------------------------------------------
// shaped_trapezoid_envelope
// Grain envelope: linear trapezoid level raised to a shape exponent, applied
// to audio samples with a gain.
// ----------------------------------------------------------------------------
// The block handles one item at a time. An item with tuser 0 starts a grain
// and gives no result: attack and decay lengths are scaled to fit the grain
// (two 40-step divisions when they do not fit) and the attack step is a
// third 40-step division, skipped when the attack is zero. An item with
// tuser 1 gives one result: the level is raised to the current shape by a
// normalize loop, sixteen squarings and up to sixteen table products on one
// shared 32x32 multiplier, all skipped when the shape is 0 or 1.0 or the
// level is 0 or full. The sample that opens a decay adds a 40-step division
// for the decay step. The divider gives one quotient bit per cycle. A
// finished result sits in the output register while the next item is
// accepted; the block waits only if it is ready to post another result
// before the first one is taken.
// Configuration writes are taken in any cycle, but must come only while no
// item is in progress.
module shaped_trapezoid_envelope (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [19:0] grain_length, [20] reversed, [36:21] sample_in, [52:37] gain
  input  logic [ste_pkg::IN_W-1:0]   s_axis_tdata,
  // [0] action
  input  logic                       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [15:0] sample_out, [31:16] env_level, [33:32] env_phase
  output logic [ste_pkg::OUT_W-1:0]  m_axis_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ste_pkg::IDX_W-1:0]  cfg_index,
  input  logic [ste_pkg::CFGD_W-1:0] cfg_data
);
  import ste_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // registers are always writable
  assign cfg_ready = 1'b1;

  ste_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ste_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ===== hw/rtl/ste_checker.sv =====
// ----------------------------------------------------------------------------
// ste_checker
// Port-level checks of the envelope block, bound to the top level.
// ----------------------------------------------------------------------------
module ste_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [ste_pkg::OUT_W-1:0]  m_axis_tdata
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // a new result is posted only while the input side is closed
  a_post_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result posted from idle");

  // phase is attack, hold or decay
  a_phase: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3)
    else $error("bad phase");

  // level never exceeds 1.0
  a_level: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[31] && (m_axis_tdata[30:16] != 15'd0)))
    else $error("level above one");

endmodule

bind shaped_trapezoid_envelope ste_checker u_ste_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shaped trapezoid envelope: a directed table of
// grain starts and samples, then random grains with random idling on both
// stream sides, results checked by hand-typed rows or an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ste_pkg::*;

  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;
  localparam longint ONE_Q31  = 64'd1 << 31;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic             act;
    logic [LEN_W-1:0] glen;
    logic             rev;
    logic [SMP_W-1:0] smp;
    logic [15:0]      gain;
  } item_t;

  // laid out as on tdata: phase on top, sample in the low bits
  typedef struct packed {
    logic [1:0]       ph;
    logic [15:0]      lvl;
    logic [SMP_W-1:0] smp;
  } env_out_t;

  // one directed row; chk marks a hand-typed expectation
  typedef struct {
    item_t    it;
    bit       chk;
    env_out_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFGD_W-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  shaped_trapezoid_envelope dut (.*);

  // predictor state
  logic [LEN_W-1:0] r_alen, r_dlen;
  logic [15:0]      r_ashp, r_dshp;
  longint           lvl_q31, stp;
  logic [1:0]       ph;
  logic [LEN_W:0]   rem;
  logic [15:0]      shp_cur;
  logic [LEN_W-1:0] ea, ed, hl;
  logic [63:0]      ctab [16];

  env_out_t pending_results[$];
  int     errors = 0;
  int     cycles = 0;
  bit     hold_rx = 0;

  function automatic logic [63:0] sqrt_floor(logic [63:0] v);
    logic [63:0] r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] level_pow(logic [63:0] lv, logic [15:0] s);
    logic [63:0] m, neg, e, f, r, q;
    int k, fr;
    k = 0;
    fr = 0;
    if (s == 0 || lv >= ONE_Q31) return ONE_Q31;
    if (lv == 0) return 0;
    if (s == SHAPE_ONE) return lv;
    m = lv;
    while (m < ONE_Q31) begin
      m = m << 1;
      k++;
    end
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      fr = fr << 1;
      if (m >= (64'd1 << 32)) begin
        fr = fr | 1;
        m = m >> 1;
      end
    end
    neg = (64'(k) << 16) - 64'(fr);
    e = (neg * s) >> 12;
    q = e >> 16;
    if (q > 31) return 0;
    f = e & 64'hFFFF;
    r = ONE_Q31;
    for (int i = 15; i >= 0; i--)
      if (f[i]) r = (r * ctab[i]) >> 31;
    return r >> q;
  endfunction

  task automatic predict_reset();
    r_alen = 480;
    r_dlen = 480;
    r_ashp = SHAPE_ONE;
    r_dshp = SHAPE_ONE;
    lvl_q31 = 0;
    stp = 0;
    ph = PH_ATTACK;
    rem = 0;
    shp_cur = 0;
    ea = 0;
    ed = 0;
    hl = 0;
    ctab[15] = sqrt_floor(64'd1 << 61);
    for (int j = 15; j > 0; j--) ctab[j-1] = sqrt_floor(ctab[j] << 31);
  endtask

  // advance the envelope by one item; returns 1 with the result for a sample
  function automatic bit envelope_step(item_t it, output env_out_t o);
    logic [63:0] a, d, sum, mag, p, m1, m2;
    logic [LEN_W:0] old_rem;
    longint nl;
    o = '0;
    if (it.act == ACT_START) begin
      a = r_alen;
      d = r_dlen;
      sum = a + d;
      if (64'(it.glen) < sum) begin
        a = (a * it.glen) / sum;
        d = (d * it.glen) / sum;
      end
      if (it.rev) {a, d} = {d, a};
      ea = a[LEN_W-1:0];
      ed = d[LEN_W-1:0];
      hl = LEN_W'(64'(it.glen) - a - d);
      lvl_q31 = 0;
      ph = PH_ATTACK;
      rem = (LEN_W+1)'(a);
      shp_cur = r_ashp;
      if (a != 0) stp = ONE_Q31 / a;
      else begin
        lvl_q31 = ONE_Q31;
        ph = PH_HOLD;
        stp = 0;
        shp_cur = SHAPE_ONE;
        rem = {1'b0, hl};
      end
      return 0;
    end
    mag = it.smp[SMP_W-1] ? 64'((17'h10000) - it.smp) : 64'(it.smp);
    p = level_pow(64'(lvl_q31), shp_cur);
    m1 = (mag * p) >> 31;
    m2 = (m1 * it.gain) >> 14;
    if (it.smp[SMP_W-1]) begin
      if (m2 > 32768) m2 = 32768;
      o.smp = SMP_W'(17'h10000 - m2);
    end else begin
      if (m2 > 32767) m2 = 32767;
      o.smp = m2[SMP_W-1:0];
    end
    o.lvl = 16'(lvl_q31 >> 16);
    o.ph = ph;
    old_rem = rem;
    rem = rem - 1'b1;
    if (old_rem != 0) begin
      nl = lvl_q31 + stp;
      if (nl < 0) nl = 0;
      if (nl > ONE_Q31) nl = ONE_Q31;
      lvl_q31 = nl;
    end else if (ph == PH_ATTACK) begin
      ph = PH_HOLD;
      lvl_q31 = ONE_Q31;
      stp = 0;
      shp_cur = SHAPE_ONE;
      rem = {1'b0, hl};
    end else if (ph == PH_HOLD) begin
      ph = PH_DECAY;
      rem = {1'b0, ed};
      shp_cur = r_dshp;
      if (ed != 0) stp = -(ONE_Q31 / ed);
      else begin
        lvl_q31 = 0;
        stp = 0;
      end
    end
    return 1;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFGD_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ATTACK_LEN:   r_alen = val;
      REG_DECAY_LEN:    r_dlen = val;
      REG_ATTACK_SHAPE: r_ashp = val[15:0];
      default:          r_dshp = val[15:0];
    endcase
  endtask

  // present one item, hold it until the handshake, then predict
  task automatic send_item(item_t it, bit chk, env_out_t res, bit gaps);
    env_out_t o;
    int g;
    g = gaps ? gap_len() : 0;
    repeat (g + 1) @(negedge clk);
    s_axis_tdata  <= IN_W'({it.gain, it.smp, it.rev, it.glen});
    s_axis_tuser  <= it.act;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (envelope_step(it, o)) begin
      if (chk && o != res)
        $display("table row disagrees with predictor: %h vs %h", res, o);
      pending_results.push_back(chk ? res : o);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  // drain: wait for every result, then the block's own settle time
  task automatic wait_idle();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic item_t mk(logic act, int glen, logic rev, int smp, int gain);
    item_t it;
    it.act = act;
    it.glen = LEN_W'(glen);
    it.rev = rev;
    it.smp = SMP_W'(smp);
    it.gain = 16'(gain);
    return it;
  endfunction

  // output side: random stalls, compare each item with the oldest expectation
  always @(negedge clk) begin
    if (rst || hold_rx) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) < 30) ? 1'b0 : 1'b1;
  end

  always @(posedge clk) begin
    env_out_t got, want;
    cycles <= cycles + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[33:0];
      if (pending_results.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("mismatch: sample exp %h got %h, level exp %h got %h, phase exp %0d got %0d",
                     want.smp, got.smp, want.lvl, got.lvl, want.ph, got.ph);
        end
      end
    end
  end

  // timeout watchdog
  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  row_t table_rows[$];
  env_out_t none;

  initial begin
    item_t it;
    int n_rand;
    int ngr;
    row_t rw;
    none = '0;
    predict_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table: sample before any start is passed straight through
    rw.it = mk(ACT_SAMPLE, 0, 0, 32767, 16384); rw.chk = 1;
    rw.res = '{smp: 16'h7fff, lvl: 16'h0000, ph: PH_ATTACK}; table_rows.push_back(rw);
    rw.it = mk(ACT_SAMPLE, 0, 0, -32768, 65535); rw.chk = 1;
    rw.res = '{smp: 16'h8000, lvl: 16'h8000, ph: PH_HOLD}; table_rows.push_back(rw);
    rw.chk = 0; rw.res = none;
    // zero-length grain: zero attack, zero decay right away
    rw.it = mk(ACT_START, 0, 0, 0, 0); table_rows.push_back(rw);
    rw.it = mk(ACT_SAMPLE, 0, 0, 1000, 16384); table_rows.push_back(rw);
    rw.it = mk(ACT_SAMPLE, 0, 0, -1000, 16384); table_rows.push_back(rw);
    rw.it = mk(ACT_SAMPLE, 0, 0, 1000, 16384); table_rows.push_back(rw);
    // scaled grain, reversed, max length bits set
    rw.it = mk(ACT_START, 10, 1, 0, 0); table_rows.push_back(rw);
    for (int i = 0; i < 13; i++) begin
      rw.it = mk(ACT_SAMPLE, 0, 0, (i % 2) ? -32768 : 32767, (i * 5000) & 16'hffff);
      table_rows.push_back(rw);
    end
    rw.it = mk(ACT_START, 20'hfffff, 1, 16'hffff, 16'hffff); table_rows.push_back(rw);
    rw.it = mk(ACT_SAMPLE, 20'hfffff, 1, 16'hffff, 16'hffff); table_rows.push_back(rw);

    foreach (table_rows[i]) send_item(table_rows[i].it, table_rows[i].chk,
                                      table_rows[i].res, 0);
    wait_idle();

    // random phases: each has its own register setting, extremes included
    for (int phs = 0; phs < 6; phs++) begin
      case (phs)
        0: begin
          write_reg(REG_ATTACK_LEN, 3); write_reg(REG_DECAY_LEN, 4);
          write_reg(REG_ATTACK_SHAPE, 8192); write_reg(REG_DECAY_SHAPE, 2048);
        end
        1: begin
          write_reg(REG_ATTACK_LEN, 0); write_reg(REG_DECAY_LEN, 0);
          write_reg(REG_ATTACK_SHAPE, 0); write_reg(REG_DECAY_SHAPE, 16'hffff);
        end
        2: begin
          write_reg(REG_ATTACK_LEN, 20'hfffff); write_reg(REG_DECAY_LEN, 20'hfffff);
          write_reg(REG_ATTACK_SHAPE, 16'hffff); write_reg(REG_DECAY_SHAPE, 0);
        end
        default: begin
          write_reg(REG_ATTACK_LEN, $urandom_range(0, 12));
          write_reg(REG_DECAY_LEN, $urandom_range(0, 12));
          write_reg(REG_ATTACK_SHAPE, $urandom_range(0, 65535));
          write_reg(REG_DECAY_SHAPE, $urandom_range(0, 65535));
        end
      endcase
      n_rand = 0;
      while (n_rand < 70) begin
        // well-formed grain: a start then 1 to 40 samples
        it = mk(ACT_START, ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 30),
                $urandom_range(0, 1), $urandom(), $urandom());
        send_item(it, 0, none, 1);
        ngr = $urandom_range(1, 40);
        for (int k = 0; k < ngr; k++) begin
          it = mk(ACT_SAMPLE, $urandom(), $urandom_range(0, 1), $urandom(), $urandom());
          if ($urandom_range(0, 9) == 0) it.smp = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
          send_item(it, 0, none, 1);
          n_rand++;
        end
        // hold the receiver after each early grain of phase 1 to let the output back up
        if (phs == 1 && n_rand < 10) begin
          hold_rx = 1;
          repeat (50) @(negedge clk);
          hold_rx = 0;
        end
      end
      // sender waits for every result before the next setting
      wait_idle();
    end

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // unexpected leftovers show up as a hang, caught by the watchdog; final
  // leftovers after the drain cannot exist since wait_idle empties the queue
endmodule
